>>> rtl/soq_pkg.sv
// Package for the serial ordered slot queue: sizes, codes and the cell types.
// No dependencies.
package soq_pkg;

    localparam int SLOTS = 16;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_POP   = 2'd1,
        CMD_POPSR = 2'd2,
        CMD_FREE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NOT_POPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_FREE   = 2'd0,
        PH_QUEUED = 2'd1,
        PH_POPPED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_DONE
    } state_t;

    // one list entry as held in a cell
    typedef struct packed {
        logic        vld;
        logic [SW-1:0] slot;
        logic [31:0] serial;
    } entry_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic        load;     // capture this cycle's shift input
        logic        ins_dir;  // 1: entries move towards tail (insert)
        logic [CW-1:0] pos;    // cell index where insert or removal happens
        entry_t      new_ent;
    } cell_ctl_t;

endpackage

>>> rtl/soq_cell.sv
// One cell of the ordered list; holds a single entry and passes it on.
// Depends on soq_pkg.
module soq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [soq_pkg::CW-1:0] idx,
    input  soq_pkg::cell_ctl_t ctl,
    input  soq_pkg::entry_t    prev_ent,
    input  soq_pkg::entry_t    next_ent,
    output soq_pkg::entry_t    ent
);
    soq_pkg::entry_t ent_next;
    logic                    vld_reg;
    logic [soq_pkg::SW-1:0]  slot_reg;
    logic [31:0]             serial_reg;

    always_comb
    begin
        ent_next.vld = vld_reg;
        ent_next.slot = slot_reg;
        ent_next.serial = serial_reg;
        if (ctl.load)
        begin
            if (ctl.ins_dir)
            begin
                if (idx == ctl.pos)
                    ent_next = ctl.new_ent;
                else if (idx > ctl.pos)
                    ent_next = prev_ent;
            end
            else if (idx >= ctl.pos)
                ent_next = next_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= ent_next.vld;
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= ent_next.slot;
        serial_reg <= ent_next.serial;
    end

    assign ent.vld = vld_reg;
    assign ent.slot = slot_reg;
    assign ent.serial = serial_reg;
endmodule

>>> rtl/soq_chain.sv
// Row of SLOTS list cells; cell 0 is the head. Entries shift as one row.
// Depends on soq_pkg and soq_cell.
module soq_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  soq_pkg::cell_ctl_t ctl,
    output soq_pkg::entry_t    ents [soq_pkg::SLOTS]
);
    soq_pkg::entry_t empty_ent;
    assign empty_ent = '0;

    for (genvar g = 0; g < soq_pkg::SLOTS; g++)
    begin : g_cell
        soq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (soq_pkg::CW'(g)),
            .ctl      (ctl),
            .prev_ent ((g == 0) ? empty_ent : ents[(g == 0) ? 0 : g - 1]),
            .next_ent ((g == soq_pkg::SLOTS - 1) ? empty_ent
                       : ents[(g == soq_pkg::SLOTS - 1) ? g : g + 1]),
            .ent      (ents[g])
        );
    end
endmodule

>>> rtl/serial_ordered_slot_queue.sv
// Top level of the serial ordered slot queue: command sequencer, free stack
// and phase table. Depends on soq_pkg and soq_chain.
//
// One command at a time. Insert and pop-by-serial walk the list one cell per
// cycle through a single selected cell. Free and a command that fails at once
// (no free slot, empty list) go from the walk state straight to the done state;
// pop head, an insert and a pop-by-serial hit pass through the shift state, and
// a pop-by-serial miss ends its walk at the last entry and goes to the done state.
// The list update itself is a single parallel shift of the cell row. Results sit
// in an output register, so the next command is accepted the cycle after the
// result is loaded; the done state waits until the previous result has gone.
// No clearing pass is needed after reset.
module serial_ordered_slot_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[1:0], serial[33:2], slot_in[37:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // ok[0], status[3:1], slot_out[7:4], serial_out[39:8],
                                   // queued_count[44:40], free_count[49:45], zero
);
    localparam int SW = soq_pkg::SW;
    localparam int CW = soq_pkg::CW;

    logic order_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 1'b1;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    soq_pkg::state_t state_reg, state_next;
    soq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]     ser_reg, ser_next;
    logic [SW-1:0]   sin_reg, sin_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   fdep_reg, fdep_next;
    logic [SW-1:0]   fstk_reg [soq_pkg::SLOTS];
    logic [1:0]      phase_reg [soq_pkg::SLOTS];
    logic            fpush, ph_we;
    logic [SW-1:0]   ph_idx;
    soq_pkg::phase_t ph_val;
    logic [SW-1:0]   alloc_slot_reg, alloc_slot_next;

    // result fields and output register
    soq_pkg::status_t st_reg, st_next;
    logic [SW-1:0]   so_reg, so_next;
    logic [31:0]     sero_reg, sero_next;
    logic [55:0]     out_reg, out_next;
    logic            mv_reg, mv_next;

    soq_pkg::cell_ctl_t ctl;
    soq_pkg::entry_t    ents [soq_pkg::SLOTS];
    soq_pkg::entry_t    cur;

    soq_chain u_chain (.clk(clk), .rst_n(rst_n), .ctl(ctl), .ents(ents));

    assign cur = ents[pos_reg[SW-1:0]];

    logic stop_ins;
    always_comb
    begin
        stop_ins = order_reg ? (cur.serial >= ser_reg) : (cur.serial <= ser_reg);
    end

    assign s_tready = (state_reg == soq_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        ser_next = ser_reg;
        sin_next = sin_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        fdep_next = fdep_reg;
        alloc_slot_next = alloc_slot_reg;
        st_next = st_reg;
        so_next = so_reg;
        sero_next = sero_reg;
        out_next = out_reg;
        mv_next = mv_reg;
        fpush = 1'b0;
        ph_we = 1'b0;
        ph_idx = '0;
        ph_val = soq_pkg::PH_FREE;
        ctl = '0;
        ctl.pos = pos_reg;
        ctl.new_ent.vld = 1'b1;
        ctl.new_ent.slot = alloc_slot_reg;
        ctl.new_ent.serial = ser_reg;

        if (mv_reg && m_tready)
            mv_next = 1'b0;

        case (state_reg)
            soq_pkg::S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next = soq_pkg::cmd_t'(s_tdata[1:0]);
                    ser_next = s_tdata[33:2];
                    sin_next = s_tdata[37:34];
                    pos_next = '0;
                    state_next = soq_pkg::S_WALK;
                end
            end
            soq_pkg::S_WALK:
            begin
                state_next = soq_pkg::S_DONE;
                case (cmd_reg)
                    soq_pkg::CMD_ALLOC:
                    begin
                        if (fdep_reg == '0)
                            st_next = soq_pkg::ST_NO_FREE;
                        else
                        begin
                            alloc_slot_next = fstk_reg[SW'(fdep_reg - CW'(1))];
                            if (pos_reg < len_reg && !stop_ins)
                            begin
                                pos_next = pos_reg + CW'(1);
                                state_next = soq_pkg::S_WALK;
                            end
                            else
                                state_next = soq_pkg::S_SHIFT;
                        end
                    end
                    soq_pkg::CMD_POP,
                    soq_pkg::CMD_POPSR:
                    begin
                        if (len_reg == '0)
                            st_next = soq_pkg::ST_EMPTY;
                        else if (cmd_reg == soq_pkg::CMD_POP
                                 || cur.serial == ser_reg)
                        begin
                            so_next = cur.slot;
                            sero_next = cur.serial;
                            state_next = soq_pkg::S_SHIFT;
                        end
                        else if (pos_reg + CW'(1) < len_reg)
                        begin
                            pos_next = pos_reg + CW'(1);
                            state_next = soq_pkg::S_WALK;
                        end
                        else
                            st_next = soq_pkg::ST_NOT_FOUND;
                    end
                    default:
                    begin
                        if (phase_reg[sin_reg] != soq_pkg::PH_POPPED
                            || fdep_reg >= CW'(soq_pkg::SLOTS))
                            st_next = soq_pkg::ST_NOT_POPPED;
                        else
                        begin
                            fpush = 1'b1;
                            fdep_next = fdep_reg + CW'(1);
                            ph_we = 1'b1;
                            ph_idx = sin_reg;
                            ph_val = soq_pkg::PH_FREE;
                            st_next = soq_pkg::ST_OK;
                        end
                    end
                endcase
                if (state_next == soq_pkg::S_DONE)
                begin
                    so_next = '0;
                    sero_next = '0;
                end
            end
            soq_pkg::S_SHIFT:
            begin
                ctl.load = 1'b1;
                st_next = soq_pkg::ST_OK;
                ph_we = 1'b1;
                if (cmd_reg == soq_pkg::CMD_ALLOC)
                begin
                    ctl.ins_dir = 1'b1;
                    len_next = len_reg + CW'(1);
                    fdep_next = fdep_reg - CW'(1);
                    ph_idx = alloc_slot_reg;
                    ph_val = soq_pkg::PH_QUEUED;
                    so_next = alloc_slot_reg;
                    sero_next = ser_reg;
                end
                else
                begin
                    len_next = len_reg - CW'(1);
                    ph_idx = so_reg;
                    ph_val = soq_pkg::PH_POPPED;
                end
                state_next = soq_pkg::S_DONE;
            end
            soq_pkg::S_DONE:
            begin
                // load the output register once the previous result has gone
                if (!mv_reg || m_tready)
                begin
                    out_next = {6'b0, fdep_reg, len_reg, sero_reg, so_reg, st_reg,
                                (st_reg == soq_pkg::ST_OK)};
                    mv_next = 1'b1;
                    state_next = soq_pkg::S_IDLE;
                end
            end
            default: state_next = soq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= soq_pkg::S_IDLE;
            len_reg <= '0;
            fdep_reg <= CW'(soq_pkg::SLOTS);
            mv_reg <= 1'b0;
            for (int i = 0; i < soq_pkg::SLOTS; i++)
            begin
                fstk_reg[i] <= SW'(soq_pkg::SLOTS - 1 - i);
                phase_reg[i] <= soq_pkg::PH_FREE;
            end
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            fdep_reg <= fdep_next;
            mv_reg <= mv_next;
            if (fpush)
                fstk_reg[fdep_reg[SW-1:0]] <= sin_reg;
            if (ph_we)
                phase_reg[ph_idx] <= ph_val;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ser_reg <= ser_next;
        sin_reg <= sin_next;
        pos_reg <= pos_next;
        alloc_slot_reg <= alloc_slot_next;
        st_reg <= st_next;
        so_reg <= so_next;
        sero_reg <= sero_next;
        out_reg <= out_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = out_reg;

    property p_len_bound;
        @(posedge clk) disable iff (!rst_n) len_reg + fdep_reg <= CW'(soq_pkg::SLOTS);
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("slot count exceeded");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == soq_pkg::S_IDLE)
        else $error("ready outside idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(out_reg) && m_tvalid)
        else $error("result changed while stalled");
endmodule

>>> dv/serial_ordered_slot_queue_tb.sv
// Self-checking testbench for serial_ordered_slot_queue: directed and random command
// streams, checked against an in-bench model of the slot pool and the ordered list.
// Depends on soq_pkg and the RTL of the block.
module serial_ordered_slot_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             ok;
        soq_pkg::status_t status;
        logic [3:0]       slot_out;
        logic [31:0]      serial_out;
        logic [4:0]       queued_count;
        logic [4:0]       free_count;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    serial_ordered_slot_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // model state
    logic            mdl_ascending;
    logic [31:0]     mdl_serial [soq_pkg::SLOTS];
    logic [3:0]      mdl_list [soq_pkg::SLOTS];
    int unsigned     mdl_len;
    logic [3:0]      mdl_free [soq_pkg::SLOTS];
    int unsigned     mdl_depth;
    soq_pkg::phase_t mdl_phase [soq_pkg::SLOTS];

    result_t       pending_results [$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    bit            calm;            // no idling on either side while set
    int unsigned   hold_req;        // bumped to ask the receiver for a long stall
    int unsigned   hold_seen;
    int unsigned   hold_left;       // receiver stall still to run, in cycles
    logic [31:0]   serial_pool [8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic result_t predict_command(soq_pkg::cmd_t cmd, logic [31:0] ser,
                                                logic [3:0] sin);
        result_t     r;
        int unsigned pos;
        int unsigned s;
        logic [31:0] cur;
        r = '0;
        r.status = soq_pkg::ST_OK;
        case (cmd)
            soq_pkg::CMD_ALLOC:
            begin
                if (mdl_depth == 0)
                    r.status = soq_pkg::ST_NO_FREE;
                else
                begin
                    mdl_depth--;
                    s = mdl_free[mdl_depth];
                    mdl_serial[s] = ser;
                    for (pos = 0; pos < mdl_len; pos++)
                    begin
                        cur = mdl_serial[mdl_list[pos]];
                        if (mdl_ascending ? (cur >= ser) : (cur <= ser))
                            break;
                    end
                    for (int i = mdl_len; i > pos; i--)
                        mdl_list[i] = mdl_list[i-1];
                    mdl_list[pos] = s[3:0];
                    mdl_len++;
                    mdl_phase[s] = soq_pkg::PH_QUEUED;
                    r.slot_out = s[3:0];
                    r.serial_out = ser;
                end
            end
            soq_pkg::CMD_POP, soq_pkg::CMD_POPSR:
            begin
                if (mdl_len == 0)
                    r.status = soq_pkg::ST_EMPTY;
                else
                begin
                    pos = mdl_len;
                    if (cmd == soq_pkg::CMD_POP)
                        pos = 0;
                    else
                        for (int i = 0; i < mdl_len; i++)
                            if (mdl_serial[mdl_list[i]] == ser)
                            begin
                                pos = i;
                                break;
                            end
                    if (pos == mdl_len)
                        r.status = soq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        s = mdl_list[pos];
                        for (int i = pos; i + 1 < mdl_len; i++)
                            mdl_list[i] = mdl_list[i+1];
                        mdl_len--;
                        mdl_phase[s] = soq_pkg::PH_POPPED;
                        r.slot_out = s[3:0];
                        r.serial_out = mdl_serial[s];
                    end
                end
            end
            default:
            begin
                if (mdl_phase[sin] != soq_pkg::PH_POPPED || mdl_depth >= soq_pkg::SLOTS)
                    r.status = soq_pkg::ST_NOT_POPPED;
                else
                begin
                    mdl_free[mdl_depth] = sin;
                    mdl_depth++;
                    mdl_phase[sin] = soq_pkg::PH_FREE;
                end
            end
        endcase
        r.ok = (r.status == soq_pkg::ST_OK);
        r.queued_count = mdl_len[4:0];
        r.free_count = mdl_depth[4:0];
        return r;
    endfunction

    // receiver: random stalls, long hold-off on request, result check
    always @(posedge clk or negedge rst_n)
    begin
        result_t     want;
        logic [55:0] raw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                raw = m_tdata;
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (raw[0] !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, raw[0]);
                        error_count++;
                    end
                    if (raw[3:1] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, raw[3:1]);
                        error_count++;
                    end
                    if (raw[7:4] !== want.slot_out)
                    begin
                        $error("slot_out: expected %0d, got %0d", want.slot_out, raw[7:4]);
                        error_count++;
                    end
                    if (raw[39:8] !== want.serial_out)
                    begin
                        $error("serial_out: expected %h, got %h", want.serial_out, raw[39:8]);
                        error_count++;
                    end
                    if (raw[44:40] !== want.queued_count)
                    begin
                        $error("queued_count: expected %0d, got %0d",
                               want.queued_count, raw[44:40]);
                        error_count++;
                    end
                    if (raw[49:45] !== want.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, raw[49:45]);
                        error_count++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= 300;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic send_command(soq_pkg::cmd_t cmd, logic [31:0] ser, logic [3:0] sin);
        int unsigned gap;
        if (!calm && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, sin, ser, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_command(cmd, ser, sin));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_order(logic asc);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= asc;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_ascending = asc;
    endtask

    function automatic logic [31:0] pick_serial();
        if ($urandom_range(3) == 0)
            return $urandom();
        return serial_pool[$urandom_range(7)];
    endfunction

    function automatic logic [3:0] pick_popped_slot();
        logic [3:0] cand [$];
        for (int i = 0; i < soq_pkg::SLOTS; i++)
            if (mdl_phase[i] == soq_pkg::PH_POPPED)
                cand.push_back(i[3:0]);
        if (cand.size() == 0)
            return $urandom_range(15);
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    task automatic test_empty_pool_errors();
        send_command(soq_pkg::CMD_POP, 32'h0, 4'h0);
        send_command(soq_pkg::CMD_POPSR, 32'hFFFF_FFFF, 4'h0);
        send_command(soq_pkg::CMD_FREE, 32'h0, 4'h0);
        send_command(soq_pkg::CMD_FREE, 32'h0, 4'hF);
    endtask

    task automatic test_fill_and_drain();
        // extremes and duplicate serials; duplicates go ahead of equal ones
        send_command(soq_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 4'h0);
        send_command(soq_pkg::CMD_ALLOC, 32'h0000_0000, 4'h0);
        send_command(soq_pkg::CMD_ALLOC, 32'h0000_0005, 4'h0);
        send_command(soq_pkg::CMD_ALLOC, 32'h0000_0005, 4'h0);
        for (int i = 0; i < 12; i++)
            send_command(soq_pkg::CMD_ALLOC, $urandom(), 4'h0);
        send_command(soq_pkg::CMD_ALLOC, 32'h1234_5678, 4'h0);      // no free slot
        send_command(soq_pkg::CMD_FREE, 32'h0, 4'h3);               // queued, not popped
        send_command(soq_pkg::CMD_POPSR, 32'hDEAD_0001, 4'h0);      // not found
        send_command(soq_pkg::CMD_POPSR, 32'h0000_0005, 4'h0);
        send_command(soq_pkg::CMD_POP, 32'h0, 4'h0);
        send_command(soq_pkg::CMD_FREE, 32'h0, pick_popped_slot());
        send_command(soq_pkg::CMD_FREE, 32'h0, 4'h0);
    endtask

    task automatic test_order_switch_with_entries();
        write_order(1'b0);
        for (int i = 0; i < 4; i++)
            send_command(soq_pkg::CMD_ALLOC, serial_pool[i], 4'h0);
        for (int i = 0; i < soq_pkg::SLOTS; i++)
            send_command(soq_pkg::CMD_POP, 32'h0, 4'h0);
        write_order(1'b1);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned   roll;
        soq_pkg::cmd_t c;
        for (int n = 0; n < count; n++)
        begin
            if (n % 300 == 0)
                calm = ($urandom_range(2) == 0);
            roll = $urandom_range(99);
            if (roll < 40)
                c = soq_pkg::CMD_ALLOC;
            else if (roll < 58)
                c = soq_pkg::CMD_POP;
            else if (roll < 75)
                c = soq_pkg::CMD_POPSR;
            else
                c = soq_pkg::CMD_FREE;
            if (c == soq_pkg::CMD_FREE && $urandom_range(9) != 0)
                send_command(c, $urandom(), pick_popped_slot());
            else
                send_command(c, pick_serial(), 4'($urandom_range(15)));
        end
        calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req++;
        for (int i = 0; i < 20; i++)
            send_command(soq_pkg::cmd_t'($urandom_range(3)), pick_serial(),
                         pick_popped_slot());
        // sender pauses until all results are back
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        hold_req = 0;
        mdl_ascending = 1'b1;
        mdl_len = 0;
        mdl_depth = soq_pkg::SLOTS;
        for (int i = 0; i < soq_pkg::SLOTS; i++)
        begin
            mdl_serial[i] = '0;
            mdl_list[i] = '0;
            mdl_free[i] = 4'(soq_pkg::SLOTS - 1 - i);
            mdl_phase[i] = soq_pkg::PH_FREE;
        end
        serial_pool = '{32'h0, 32'hFFFF_FFFF, 32'h7, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'hA5A5_5A5A, 32'h100, 32'h7};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool_errors();
        test_fill_and_drain();
        test_order_switch_with_entries();
        test_random_traffic(600);
        write_order(1'b0);
        test_random_traffic(500);
        test_output_backpressure();
        write_order(1'b1);
        test_random_traffic(600);
        test_output_backpressure();
        drain_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // $error calls above also count through error_count
endmodule
